[rtl/au_packetizer_fragment_aggregate_defines.svh]
`ifndef AU_PACKETIZER_FRAGMENT_AGGREGATE_DEFINES_SVH
`define AU_PACKETIZER_FRAGMENT_AGGREGATE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define AUPFA_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aupfa: same-cycle check failed");

// next-cycle implication
`define AUPFA_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aupfa: next-cycle check failed");

`endif

[rtl/aupfa_pkg.sv]
package aupfa_pkg;

  localparam int STACK_DEPTH = 3;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int AGG_SLOTS   = 3;
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam int UNIT_W  = 16;
  localparam int MTU_W   = 14;
  localparam int HDR_W   = 6;
  localparam int SZ_W    = 13;
  localparam int IDX_W   = 3;
  localparam int FLAG_W  = 3;
  localparam int ACC_W   = UNIT_W + 2;

  localparam int AUDIO_HDR     = 7;
  localparam int PKT_OVERHEAD  = 4;
  localparam int FRAG_HDR_BITS = 'h0010;
  localparam int MTU_MIN       = 1100;
  localparam int MTU_MAX       = 9216;
  localparam int MTU_RESET     = 1500;

  // flag bit positions
  localparam int FB_AUDIO = 0;
  localparam int FB_START = 1;
  localparam int FB_END   = 2;

  // config register indexes
  localparam logic REG_MTU = 1'b0;
  localparam logic REG_AGG = 1'b1;

  typedef logic [3:0] op_t;
  typedef logic [3:0] cond_t;
  typedef logic [3:0] pc_t;

  localparam op_t OP_NOP       = 4'd0;
  localparam op_t OP_LOAD      = 4'd1;
  localparam op_t OP_SETRET    = 4'd2;
  localparam op_t OP_AGG       = 4'd3;
  localparam op_t OP_AGG_LAST  = 4'd4;
  localparam op_t OP_FSET_STK  = 4'd5;
  localparam op_t OP_FSET_ITEM = 4'd6;
  localparam op_t OP_FRAG      = 4'd7;
  localparam op_t OP_PUSH      = 4'd8;

  localparam cond_t C_NEVER      = 4'd0;
  localparam cond_t C_ALWAYS     = 4'd1;
  localparam cond_t C_NOT_VALID  = 4'd2;
  localparam cond_t C_DIRECT     = 4'd3;
  localparam cond_t C_NO_FLUSH   = 4'd4;
  localparam cond_t C_CNT_ZERO   = 4'd5;
  localparam cond_t C_CNT_ONE    = 4'd6;
  localparam cond_t C_FRAG_MORE  = 4'd7;
  localparam cond_t C_NOT_STACK  = 4'd8;
  localparam cond_t C_RET_FRAG   = 4'd9;
  localparam cond_t C_PUSH_STAYS = 4'd10;

  localparam pc_t S_IDLE      = 4'd0;
  localparam pc_t S_CLASS     = 4'd1;
  localparam pc_t S_ROUTE     = 4'd2;
  localparam pc_t S_FL_EMPTY  = 4'd3;
  localparam pc_t S_FL_ONE    = 4'd4;
  localparam pc_t S_FL_AGG    = 4'd5;
  localparam pc_t S_FSET_STK  = 4'd6;
  localparam pc_t S_FSET_ITEM = 4'd7;
  localparam pc_t S_FRAG      = 4'd8;
  localparam pc_t S_FRAG_EXIT = 4'd9;
  localparam pc_t S_POST      = 4'd10;
  localparam pc_t S_PUSH      = 4'd11;
  localparam pc_t S_PUSH_FL   = 4'd12;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic direct;
    logic no_flush;
    logic cnt_zero;
    logic cnt_one;
    logic frag_more;
    logic from_stack;
    logic ret_frag;
    logic push_stays;
    logic stack_full;
    logic stall;
  } status_t;

  // result word, lowest field last
  typedef struct packed {
    logic              pkt_frame_end;
    logic              pkt_frame_start;
    logic [UNIT_W-1:0] frag_offset;
    logic [MTU_W-1:0]  payload_len;
    logic [IDX_W-1:0]  au_index;
    logic [SZ_W-1:0]   size_third;
    logic [SZ_W-1:0]   size_second;
    logic [SZ_W-1:0]   size_first;
    logic [HDR_W-1:0]  header_bits;
    logic [UNIT_W-1:0] unit_number;
  } pkt_t;

  // control store: branch taken goes to target, else next step
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    unique case (pc)
      S_IDLE:      w = '{OP_LOAD,      C_NOT_VALID,  S_IDLE};
      S_CLASS:     w = '{OP_NOP,       C_DIRECT,     S_FSET_ITEM};
      S_ROUTE:     w = '{OP_SETRET,    C_NO_FLUSH,   S_PUSH};
      S_FL_EMPTY:  w = '{OP_NOP,       C_CNT_ZERO,   S_POST};
      S_FL_ONE:    w = '{OP_NOP,       C_CNT_ONE,    S_FSET_STK};
      S_FL_AGG:    w = '{OP_AGG,       C_ALWAYS,     S_POST};
      S_FSET_STK:  w = '{OP_FSET_STK,  C_ALWAYS,     S_FRAG};
      S_FSET_ITEM: w = '{OP_FSET_ITEM, C_NEVER,      S_IDLE};
      S_FRAG:      w = '{OP_FRAG,      C_FRAG_MORE,  S_FRAG};
      S_FRAG_EXIT: w = '{OP_NOP,       C_NOT_STACK,  S_IDLE};
      S_POST:      w = '{OP_NOP,       C_RET_FRAG,   S_FSET_ITEM};
      S_PUSH:      w = '{OP_PUSH,      C_PUSH_STAYS, S_IDLE};
      S_PUSH_FL:   w = '{OP_AGG_LAST,  C_ALWAYS,     S_IDLE};
      default:     w = '{OP_NOP,       C_ALWAYS,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/aupfa_useq.sv]
module aupfa_useq
  import aupfa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t stat,
  output uword_t  uw,
  output pc_t     pc
);

  pc_t  pc_r, pc_nxt;
  logic taken;

  assign uw = ucode(pc_r);
  assign pc = pc_r;

  always_comb begin
    unique case (uw.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_NOT_VALID:  taken = !stat.in_valid;
      C_DIRECT:     taken = stat.direct;
      C_NO_FLUSH:   taken = stat.no_flush;
      C_CNT_ZERO:   taken = stat.cnt_zero;
      C_CNT_ONE:    taken = stat.cnt_one;
      C_FRAG_MORE:  taken = stat.frag_more;
      C_NOT_STACK:  taken = !stat.from_stack;
      C_RET_FRAG:   taken = stat.ret_frag;
      C_PUSH_STAYS: taken = stat.push_stays;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    if (stat.stall) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[rtl/aupfa_dp.sv]
module aupfa_dp
  import aupfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  uword_t            uw,
  input  logic [MTU_W-1:0]  mtu_eff,
  input  logic              agg_en,
  input  logic              in_tvalid,
  input  logic [UNIT_W-1:0] in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              in_tlast,
  output status_t           stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output pkt_t              out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  // current unit
  logic [UNIT_W-1:0] size_r;
  logic [FLAG_W-1:0] flags_r;
  logic              ret_r;
  // fragment loop
  logic [UNIT_W-1:0] fsize_r, off_r;
  logic [FLAG_W-1:0] fflags_r;
  logic              from_stack_r, chain_r;
  logic [RES_W-1:0]  cnt_r;
  // small-unit stack
  logic [UNIT_W-1:0] stk_size_r [STACK_DEPTH];
  logic [FLAG_W-1:0] stk_flag_r [STACK_DEPTH];
  logic [CNT_W-1:0]  stk_cnt_r;
  logic [UNIT_W-1:0] stk_bytes_r;
  logic [UNIT_W-1:0] unum_r;
  // output register
  logic              out_valid_r;
  pkt_t              out_pkt_r;
  logic              out_kind_r, out_last_r;

  logic [MTU_W-1:0]  chunk;
  logic [UNIT_W-1:0] rem, len16, in_size;
  logic              final_frag, cap, can_emit, emit_req, emit_en, stall;
  logic              big, over;
  logic [ACC_W-1:0]  fill, total;
  logic              agg_audio, agg_fs, agg_fe;
  logic [SZ_W-1:0]   agg_sz [AGG_SLOTS];
  pkt_t              frag_pkt, agg_pkt;
  logic              frag_last, agg_last;
  logic              is_agg_op;

  assign chunk      = mtu_eff - MTU_W'(PKT_OVERHEAD);
  assign rem        = fsize_r - off_r;
  assign final_frag = rem <= UNIT_W'(chunk);
  assign len16      = final_frag ? rem : UNIT_W'(chunk);
  assign cap        = cnt_r == RES_W'(MAX_RESULTS);

  assign in_size = (in_tuser[0] && (in_tdata > UNIT_W'(AUDIO_HDR))) ?
                   in_tdata - UNIT_W'(AUDIO_HDR) :
                   (in_tuser[0] ? '0 : in_tdata);

  assign big  = (ACC_W'(size_r) + ACC_W'(PKT_OVERHEAD)) > ACC_W'(mtu_eff);
  // 2 + (count+1)*2 + held bytes + unit
  assign fill = ACC_W'(PKT_OVERHEAD) + ACC_W'({stk_cnt_r, 1'b0})
              + ACC_W'(stk_bytes_r) + ACC_W'(size_r);
  assign over = fill > ACC_W'(mtu_eff);

  assign is_agg_op = (uw.op == OP_AGG) || (uw.op == OP_AGG_LAST);
  assign can_emit  = !out_valid_r || out_tready;
  assign emit_req  = ((uw.op == OP_FRAG) && stat.frag_more) || is_agg_op;
  assign stall     = emit_req && !can_emit;
  assign emit_en   = emit_req && can_emit && !cap;

  always_comb begin
    stat.in_valid   = in_tvalid;
    stat.direct     = flags_r[FB_AUDIO] && !agg_en;
    stat.no_flush   = !big && !over;
    stat.cnt_zero   = stk_cnt_r == '0;
    stat.cnt_one    = stk_cnt_r == CNT_W'(1);
    stat.frag_more  = (off_r < fsize_r) && !cap;
    stat.from_stack = from_stack_r;
    stat.ret_frag   = ret_r;
    stat.push_stays = (stk_cnt_r + CNT_W'(1)) < CNT_W'(STACK_DEPTH);
    stat.stack_full = stk_cnt_r == CNT_W'(STACK_DEPTH);
    stat.stall      = stall;
  end

  // aggregate of held units
  always_comb begin
    total     = '0;
    agg_fs    = 1'b0;
    agg_fe    = 1'b0;
    agg_audio = stk_flag_r[0][FB_AUDIO];
    for (int i = 0; i < AGG_SLOTS; i++) begin
      agg_sz[i] = '0;
    end
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (CNT_W'(i) < stk_cnt_r) begin
        total = total + ACC_W'(stk_size_r[i]);
        agg_fs = agg_fs | stk_flag_r[i][FB_START];
        agg_fe = agg_fe | stk_flag_r[i][FB_END];
        if (agg_audio && (i < AGG_SLOTS)) begin
          agg_sz[i] = stk_size_r[i][SZ_W-1:0];
        end
      end
    end
  end

  always_comb begin
    agg_pkt                 = '0;
    agg_pkt.unit_number     = unum_r;
    agg_pkt.header_bits     = agg_audio ? HDR_W'({stk_cnt_r, 4'b0000}) : '0;
    agg_pkt.size_first      = agg_sz[0];
    agg_pkt.size_second     = agg_sz[1];
    agg_pkt.size_third      = agg_sz[2];
    agg_pkt.payload_len     = total[MTU_W-1:0];
    agg_pkt.pkt_frame_start = agg_fs;
    agg_pkt.pkt_frame_end   = agg_fe;
    agg_last = (uw.op == OP_AGG_LAST) || !ret_r || (cnt_r == RES_W'(MAX_RESULTS - 1));

    frag_pkt                 = '0;
    frag_pkt.unit_number     = unum_r;
    frag_pkt.header_bits     = fflags_r[FB_AUDIO] ? HDR_W'(FRAG_HDR_BITS) : '0;
    frag_pkt.size_first      = fflags_r[FB_AUDIO] ? fsize_r[SZ_W-1:0] : '0;
    frag_pkt.au_index        = fflags_r[FB_AUDIO] ? unum_r[IDX_W-1:0] : '0;
    frag_pkt.payload_len     = len16[MTU_W-1:0];
    frag_pkt.frag_offset     = off_r;
    frag_pkt.pkt_frame_start = (off_r == '0) && fflags_r[FB_START];
    frag_pkt.pkt_frame_end   = final_frag && fflags_r[FB_END];
    frag_last = (final_frag && !chain_r) || (cnt_r == RES_W'(MAX_RESULTS - 1));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      stk_cnt_r    <= '0;
      stk_bytes_r  <= '0;
      unum_r       <= '0;
      cnt_r        <= '0;
      ret_r        <= 1'b0;
      from_stack_r <= 1'b0;
      chain_r      <= 1'b0;
    end else begin
      if (emit_en) begin
        out_valid_r <= 1'b1;
        unum_r      <= unum_r + UNIT_W'(1);
        cnt_r       <= cnt_r + RES_W'(1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (!stall) begin
        case (uw.op)
          OP_LOAD: begin
            if (in_tvalid) cnt_r <= '0;
          end
          OP_SETRET: ret_r <= big;
          OP_FSET_ITEM: begin
            from_stack_r <= 1'b0;
            chain_r      <= 1'b0;
          end
          OP_FSET_STK: begin
            from_stack_r <= 1'b1;
            chain_r      <= ret_r;
            stk_cnt_r    <= '0;
            stk_bytes_r  <= '0;
          end
          OP_AGG, OP_AGG_LAST: begin
            stk_cnt_r   <= '0;
            stk_bytes_r <= '0;
          end
          OP_PUSH: begin
            if (stk_cnt_r < CNT_W'(STACK_DEPTH)) begin
              stk_cnt_r   <= stk_cnt_r + CNT_W'(1);
              stk_bytes_r <= stk_bytes_r + size_r;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_pkt_r  <= is_agg_op ? agg_pkt : frag_pkt;
      out_kind_r <= is_agg_op;
      out_last_r <= is_agg_op ? agg_last : frag_last;
    end
    if (!stall) begin
      case (uw.op)
        OP_LOAD: begin
          if (in_tvalid) begin
            size_r  <= in_size;
            flags_r <= {in_tlast, in_tuser[1], in_tuser[0]};
          end
        end
        OP_FSET_ITEM: begin
          fsize_r  <= size_r;
          fflags_r <= flags_r;
          off_r    <= '0;
        end
        OP_FSET_STK: begin
          fsize_r  <= stk_size_r[0];
          fflags_r <= stk_flag_r[0];
          off_r    <= '0;
        end
        OP_FRAG: begin
          if (stat.frag_more) off_r <= off_r + len16;
        end
        OP_PUSH: begin
          for (int i = 0; i < STACK_DEPTH; i++) begin
            if (stk_cnt_r == CNT_W'(i)) begin
              stk_size_r[i] <= size_r;
              stk_flag_r[i] <= flags_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pkt_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/au_packetizer_fragment_aggregate.sv]
// Throughput: one packet word per cycle while the output side takes them; one unit
// at a time, in_tready high only in the idle step.
// Reset (rst_n low, synchronous): stack emptied, packet number 0, mtu 1500,
// aggregation off, output word dropped, in_tready low.
`include "au_packetizer_fragment_aggregate_defines.svh"
module au_packetizer_fragment_aggregate
  import aupfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [MTU_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [UNIT_W-1:0] in_tdata,   // unit_size
  input  logic [1:0]        in_tuser,   // is_audio, unit_frame_start
  input  logic              in_tlast,   // unit_frame_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,  // unit_number, header_bits, size_first,
                                        // size_second, size_third, au_index,
                                        // payload_len, frag_offset,
                                        // pkt_frame_start, pkt_frame_end
  output logic              out_tuser,  // packet_kind
  output logic              out_tlast   // last
);

  logic [MTU_W-1:0] mtu_r, mtu_eff;
  logic             agg_r;
  status_t          stat;
  uword_t           uw;
  pc_t              pc;
  pkt_t             out_pkt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r <= MTU_W'(MTU_RESET);
      agg_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MTU: mtu_r <= cfg_wdata;
        REG_AGG: agg_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign mtu_eff = (mtu_r < MTU_W'(MTU_MIN)) ? MTU_W'(MTU_MIN) :
                   (mtu_r > MTU_W'(MTU_MAX)) ? MTU_W'(MTU_MAX) : mtu_r;

  // no word is taken while reset is held
  assign in_tready = (pc == S_IDLE) && rst_n;

  aupfa_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uw    (uw),
    .pc    (pc)
  );

  aupfa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .uw         (uw),
    .mtu_eff    (mtu_eff),
    .agg_en     (agg_r),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_pkt),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = out_pkt;

  `AUPFA_HOLDS(a_idle_stack_open, in_tready, !stat.stack_full)
  `AUPFA_NEXT(a_stall_holds_step, stat.stall, $stable(pc))
  `AUPFA_NEXT(a_accept_leaves_idle, in_tvalid && in_tready, !in_tready)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import aupfa_pkg::*;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int STALL_LIMIT    = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic kind;
    logic last;
    pkt_t pkt;
  } pkt_word_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [MTU_W-1:0]  cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [UNIT_W-1:0] in_tdata;   // unit_size
  logic [1:0]        in_tuser;   // is_audio, unit_frame_start
  logic              in_tlast;   // unit_frame_end
  logic              out_tvalid;
  logic              out_tready;
  logic [95:0]       out_tdata;  // unit_number, header_bits, size_first, size_second,
                                 // size_third, au_index, payload_len, frag_offset,
                                 // pkt_frame_start, pkt_frame_end
  logic              out_tuser;  // packet_kind
  logic              out_tlast;  // last

  au_packetizer_fragment_aggregate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // packetizer state as predicted
  logic [MTU_W-1:0]  m_mtu;
  logic              m_agg;
  logic [UNIT_W-1:0] stk_size [STACK_DEPTH];
  logic [FLAG_W-1:0] stk_flag [STACK_DEPTH];
  int unsigned       stk_count;
  logic [UNIT_W-1:0] stk_bytes;
  logic [UNIT_W-1:0] pkt_counter;
  int                unit_pkts;

  pkt_word_t pending_pkts [$];
  pkt_word_t exp_word;
  pkt_word_t act_word;

  int mismatches;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_reqs;
  int holds_done;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_mtu();
    if (m_mtu < MTU_MIN) return MTU_MIN;
    if (m_mtu > MTU_MAX) return MTU_MAX;
    return m_mtu;
  endfunction

  function automatic string pkt_text(input pkt_word_t w);
    return $sformatf({"kind=%0d num=%0d hdr=%0d s1=%0d s2=%0d s3=%0d idx=%0d len=%0d ",
                      "off=%0d fs=%0d fe=%0d last=%0d"},
                     w.kind, w.pkt.unit_number, w.pkt.header_bits, w.pkt.size_first,
                     w.pkt.size_second, w.pkt.size_third, w.pkt.au_index,
                     w.pkt.payload_len, w.pkt.frag_offset, w.pkt.pkt_frame_start,
                     w.pkt.pkt_frame_end, w.last);
  endfunction

  // packets past the per-unit cap are dropped and take no number
  task automatic emit_pkt(input logic kind, input int unsigned hbits, input int unsigned s1,
                          input int unsigned s2, input int unsigned s3, input logic use_idx,
                          input int unsigned len, input int unsigned off,
                          input logic fs, input logic fe);
    pkt_word_t w;
    if (unit_pkts >= MAX_RESULTS) return;
    w = '0;
    w.kind                = kind;
    w.pkt.unit_number     = pkt_counter;
    w.pkt.header_bits     = hbits[HDR_W-1:0];
    w.pkt.size_first      = s1[SZ_W-1:0];
    w.pkt.size_second     = s2[SZ_W-1:0];
    w.pkt.size_third      = s3[SZ_W-1:0];
    w.pkt.au_index        = use_idx ? pkt_counter[IDX_W-1:0] : '0;
    w.pkt.payload_len     = len[MTU_W-1:0];
    w.pkt.frag_offset     = off[UNIT_W-1:0];
    w.pkt.pkt_frame_start = fs;
    w.pkt.pkt_frame_end   = fe;
    pkt_counter++;
    unit_pkts++;
    pending_pkts.insert(pending_pkts.size(), w);
  endtask

  task automatic fragment_unit(input int unsigned size, input logic [FLAG_W-1:0] flags);
    int unsigned chunk;
    int unsigned off;
    int unsigned len;
    logic        aud;
    chunk = eff_mtu() - PKT_OVERHEAD;
    off   = 0;
    aud   = flags[FB_AUDIO];
    while (off < size) begin
      len = (size - off < chunk) ? size - off : chunk;
      emit_pkt(1'b0, aud ? FRAG_HDR_BITS : 0, aud ? size : 0, 0, 0, aud, len, off,
               (off == 0) && flags[FB_START], (off + len == size) && flags[FB_END]);
      off += len;
    end
  endtask

  task automatic flush_stack();
    int unsigned sz [AGG_SLOTS];
    int unsigned total;
    logic        aud;
    logic        fs;
    logic        fe;
    if (stk_count == 0) return;
    if (stk_count == 1) begin
      fragment_unit(stk_size[0], stk_flag[0]);
    end else begin
      aud   = stk_flag[0][FB_AUDIO];
      total = 0;
      fs    = 1'b0;
      fe    = 1'b0;
      for (int i = 0; i < AGG_SLOTS; i++) sz[i] = 0;
      for (int i = 0; i < stk_count; i++) begin
        if (aud) sz[i] = stk_size[i];
        total += stk_size[i];
        fs |= stk_flag[i][FB_START];
        fe |= stk_flag[i][FB_END];
      end
      emit_pkt(1'b1, aud ? stk_count * 16 : 0, sz[0], sz[1], sz[2], 1'b0, total, 0, fs, fe);
    end
    stk_count = 0;
    stk_bytes = '0;
  endtask

  task automatic predict_unit(input logic [UNIT_W-1:0] size_in, input logic aud,
                              input logic fs, input logic fe);
    int unsigned       sz;
    logic [FLAG_W-1:0] flags;
    pkt_word_t         w;
    flags           = '0;
    flags[FB_AUDIO] = aud;
    flags[FB_START] = fs;
    flags[FB_END]   = fe;
    sz        = size_in;
    unit_pkts = 0;
    if (aud) sz = (sz > AUDIO_HDR) ? sz - AUDIO_HDR : 0;
    if (aud && !m_agg) begin
      fragment_unit(sz, flags);
    end else if (sz + PKT_OVERHEAD > eff_mtu()) begin
      flush_stack();
      fragment_unit(sz, flags);
    end else begin
      if (2 + (stk_count + 1) * 2 + stk_bytes + sz > eff_mtu()) flush_stack();
      if (stk_count < STACK_DEPTH) begin
        stk_size[stk_count] = sz[UNIT_W-1:0];
        stk_flag[stk_count] = flags;
        stk_count++;
        stk_bytes = stk_bytes + sz[UNIT_W-1:0];
      end
      if (stk_count >= STACK_DEPTH) flush_stack();
    end
    if (unit_pkts > 0) begin
      w = pending_pkts[pending_pkts.size() - 1];
      w.last = 1'b1;
      pending_pkts[pending_pkts.size() - 1] = w;
    end
  endtask

  // valid stays up after a handshake so back-to-back words need no extra step
  task automatic send_unit(input logic [UNIT_W-1:0] size, input logic aud,
                           input logic fs, input logic fe);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= size;
    in_tuser  <= {fs, aud};
    in_tlast  <= fe;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_unit(size, aud, fs, fe);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_pkts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // block must be idle: call only after wait_drain
  task automatic set_config(input logic [MTU_W-1:0] mtu_val, input logic agg_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MTU;
    cfg_wdata <= mtu_val;
    @(posedge clk);
    cfg_index <= REG_AGG;
    cfg_wdata <= {{(MTU_W-1){1'b0}}, agg_val};
    @(posedge clk);
    cfg_we <= 1'b0;
    m_mtu = mtu_val;
    m_agg = agg_val;
  endtask

  // mtu 1500, aggregation off
  task automatic test_reset_settings();
    send_unit(16'd7, 1'b1, 1'b1, 1'b0);      // audio no longer than its header
    send_unit(16'd0, 1'b1, 1'b0, 1'b1);
    send_unit(16'hFFFF, 1'b1, 1'b1, 1'b1);   // long audio fragment run
    send_unit(16'd0, 1'b0, 1'b1, 1'b1);      // empty video entry on the stack
    send_unit(16'd1496, 1'b0, 1'b0, 1'b0);   // overflow flush of the empty entry
    send_unit(16'd1497, 1'b0, 1'b1, 1'b0);   // just over mtu
    send_unit(16'd100, 1'b0, 1'b0, 1'b1);
    send_unit(16'd200, 1'b0, 1'b1, 1'b0);
    send_unit(16'd300, 1'b0, 1'b1, 1'b1);    // depth flush
    wait_drain();
  endtask

  task automatic test_aggregation();
    set_config(14'd1100, 1'b1);
    send_unit(16'd8, 1'b1, 1'b1, 1'b0);
    send_unit(16'd1000, 1'b0, 1'b0, 1'b1);   // mixed stack, audio first
    send_unit(16'd1200, 1'b1, 1'b0, 1'b0);
    send_unit(16'd20, 1'b1, 1'b0, 1'b0);
    send_unit(16'd30, 1'b1, 1'b1, 1'b1);
    send_unit(16'd40, 1'b0, 1'b0, 1'b0);
    wait_drain();
  endtask

  // large stacked unit, mtu lowered, then a max unit: hits the per-unit packet cap
  task automatic test_result_cap();
    set_config(14'd9216, 1'b1);
    send_unit(16'd9000, 1'b0, 1'b1, 1'b0);
    wait_drain();
    set_config(14'd0, 1'b0);
    send_unit(16'hFFFF, 1'b0, 1'b0, 1'b1);
    send_unit(16'd1, 1'b0, 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_mtu_saturation();
    set_config(14'h3FFF, 1'b1);
    send_unit(16'd9219, 1'b1, 1'b1, 1'b1);
    send_unit(16'd9220, 1'b1, 1'b0, 1'b1);
    send_unit(16'd5, 1'b1, 1'b0, 1'b0);
    send_unit(16'd6000, 1'b0, 1'b1, 1'b0);
    send_unit(16'd4000, 1'b0, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_backpressure();
    set_config(14'd1500, 1'b0);
    hold_reqs++;
    for (int i = 0; i < 8; i++) send_unit(16'd5000, 1'b0, 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_random(input int n_units, input int tx_pct, input int rx_pct);
    int unsigned      r;
    int unsigned      sz;
    logic [MTU_W-1:0] mtu_val;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_units; i++) begin
      if (i % 45 == 0) begin
        wait_drain();
        case ($urandom_range(5))
          0:       mtu_val = 14'(MTU_MIN);
          1:       mtu_val = 14'(MTU_MAX);
          2:       mtu_val = 14'(MTU_RESET);
          3, 4:    mtu_val = 14'($urandom_range(MTU_MAX, MTU_MIN));
          default: mtu_val = 14'($urandom_range(16383));
        endcase
        set_config(mtu_val, 1'($urandom_range(1)));
      end
      // mostly stackable sizes, a few long fragment runs
      r = $urandom_range(99);
      if (r < 10)      sz = $urandom_range(12);
      else if (r < 55) sz = $urandom_range(700);
      else if (r < 80) sz = $urandom_range(eff_mtu() + 8);
      else if (r < 95) sz = $urandom_range(20000);
      else             sz = $urandom_range(65535, 40000);
      send_unit(sz[UNIT_W-1:0], 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    end
    wait_drain();
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_reqs) begin
        holds_done++;
        for (int n = 0; n < RX_HOLD_CYCLES; n++) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      act_word.kind = out_tuser;
      act_word.last = out_tlast;
      act_word.pkt  = out_tdata;
      if (pending_pkts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: %s", pkt_text(act_word));
      end else begin
        exp_word = pending_pkts[0];
        pending_pkts.delete(0);
        if (act_word !== exp_word) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch exp: %s", pkt_text(exp_word));
            $display("         act: %s", pkt_text(act_word));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", stall_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_MTU;
    cfg_wdata   <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    in_tlast    <= 1'b0;
    m_mtu       = 14'(MTU_RESET);
    m_agg       = 1'b0;
    stk_count   = 0;
    stk_bytes   = '0;
    pkt_counter = '0;
    mismatches  = 0;
    hold_reqs   = 0;
    holds_done  = 0;
    tx_idle_pct = 19;
    rx_idle_pct = 53;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_aggregation();
    test_result_cap();
    test_mtu_saturation();
    test_random(130, 19, 53);
    test_random(130, 53, 19);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random(130, 0, 0);

    if (mismatches == 0 && pending_pkts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
